// ===== rtl/core/ddd_pkg.sv =====
package ddd_pkg;

  // Field widths of one word on either side.
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;

  // Years above this bound are clamped to it.
  localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);

  // Calendar constants.
  localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;
  localparam logic [6:0] YEARS_CENTURY    = 7'd100;
  localparam logic [MONTH_W-1:0] MONTH_MARCH = MONTH_W'(3);

  // Division by 100 as a multiply by a scaled reciprocal, exact for values
  // below 43690, which covers every year operand used here.
  localparam int unsigned PROD_W     = 28;
  localparam int unsigned DIV_SHIFT  = 19;
  localparam int unsigned QUOT_W     = 8;
  localparam logic [12:0] RECIP_100  = 13'd5243;

  // Days of a common year before the first day of each month code.
  localparam logic [8:0] DAYS_BEFORE_MONTH [16] = '{
    9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
  };

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

// ===== rtl/core/ddd_pipe_ctl.sv =====
module ddd_pipe_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output ddd_pkg::stage_en_t stage_en
);

  logic [4:0] vld_r;
  logic [4:0] vld_nxt;
  logic [4:0] ld;
  logic [4:0] prev_vld;

  // A stage loads when it is empty or when its word moves on this cycle.
  always_comb begin
    ld[4] = !vld_r[4] || out_tready;
    for (int k = 3; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  assign prev_vld = {vld_r[3:0], in_tvalid};

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      vld_nxt[k] = ld[k] ? prev_vld[k] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready   = ld[0];
  assign out_tvalid  = vld_r[4];
  assign stage_en.s1 = ld[0];
  assign stage_en.s2 = ld[1];
  assign stage_en.s3 = ld[2];
  assign stage_en.s4 = ld[3];
  assign stage_en.s5 = ld[4];

endmodule

// ===== rtl/core/ddd_day_number.sv =====
module ddd_day_number (
  input  logic                               clk,
  input  ddd_pkg::stage_en_t                 stage_en,
  input  logic [ddd_pkg::YEAR_W-1:0]         year,
  input  logic [ddd_pkg::MONTH_W-1:0]        month,
  input  logic [ddd_pkg::DAY_W-1:0]          day,
  output logic [ddd_pkg::COUNT_W-1:0]        day_num
);

  localparam int unsigned YW = ddd_pkg::YEAR_W;
  localparam int unsigned PW = ddd_pkg::PROD_W;
  localparam int unsigned QW = ddd_pkg::QUOT_W;
  localparam int unsigned CW = ddd_pkg::COUNT_W;

  // Stage 1: clamp the year and start the three divisions by 100.
  logic [YW-1:0]               y_sat;
  logic [YW-1:0]               y_r;
  logic [ddd_pkg::MONTH_W-1:0] m_r;
  logic [ddd_pkg::DAY_W-1:0]   d_r;
  logic [PW-1:0]               p_y_r;
  logic [PW-1:0]               p_c_r;
  logic [PW-1:0]               p_q_r;

  assign y_sat = (year > ddd_pkg::MAX_YEAR) ? ddd_pkg::MAX_YEAR : year;

  always_ff @(posedge clk) begin
    if (stage_en.s1) begin
      y_r   <= y_sat;
      m_r   <= month;
      d_r   <= day;
      p_y_r <= PW'(y_sat) * PW'(ddd_pkg::RECIP_100);
      p_c_r <= PW'(PW'(y_sat) + PW'(99)) * PW'(ddd_pkg::RECIP_100);
      p_q_r <= PW'((PW'(y_sat) + PW'(399)) >> 2) * PW'(ddd_pkg::RECIP_100);
    end
  end

  // Stage 2: leap test, year base count and in-year offset.
  logic [QW-1:0] q_y;
  logic [QW-1:0] q_c;
  logic [QW-1:0] q_q;
  logic [YW-1:0] rem_y;
  logic          leap;
  logic [CW-1:0] base_nxt;
  logic [9:0]    ofs_nxt;
  logic [CW-1:0] base_r;
  logic [9:0]    ofs_r;

  assign q_y   = p_y_r[ddd_pkg::DIV_SHIFT +: QW];
  assign q_c   = p_c_r[ddd_pkg::DIV_SHIFT +: QW];
  assign q_q   = p_q_r[ddd_pkg::DIV_SHIFT +: QW];
  assign rem_y = y_r - YW'(YW'(q_y) * YW'(ddd_pkg::YEARS_CENTURY));

  // Leap when divisible by 4 but not 100, or divisible by 400.
  assign leap = ((y_r[1:0] == 2'b00) && (rem_y != '0)) ||
                ((rem_y == '0) && (q_y[1:0] == 2'b00));

  assign base_nxt = CW'(y_r) * CW'(ddd_pkg::DAYS_COMMON_YEAR)
                  + CW'((CW'(y_r) + CW'(3)) >> 2)
                  - CW'(q_c) + CW'(q_q);

  assign ofs_nxt = 10'(ddd_pkg::DAYS_BEFORE_MONTH[m_r]) + 10'(d_r)
                 + 10'(leap && (m_r >= ddd_pkg::MONTH_MARCH));

  always_ff @(posedge clk) begin
    if (stage_en.s2) begin
      base_r <= base_nxt;
      ofs_r  <= ofs_nxt;
    end
  end

  // Stage 3: final day number.
  logic [CW-1:0] num_r;

  always_ff @(posedge clk) begin
    if (stage_en.s3) begin
      num_r <= base_r + CW'(ofs_r);
    end
  end

  assign day_num = num_r;

endmodule

// ===== rtl/core/date_difference_days_top.sv =====
// An accepted input word is registered in stages 1 to 5 before its result word shows.
// Throughput: one word per cycle while out_tready is high; the day-number
// pipeline and subtract stage each take a new word every cycle unless stalled.
// Back-pressure ripples stage by stage, so bubbles fill while a result waits.
// Reset (rst_n low, synchronous) empties the pipeline; the data registers are not reset.
module date_difference_days_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23],
  // month_b[40:37], day_b[45:41], zero fill [47:46]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // day_count[21:0], zero fill [23:22]
  output logic [23:0] out_tdata
);

  localparam int unsigned CW = ddd_pkg::COUNT_W;

  ddd_pkg::stage_en_t stage_en;
  logic [CW-1:0]      num_a;
  logic [CW-1:0]      num_b;

  ddd_pipe_ctl u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stage_en   (stage_en)
  );

  ddd_day_number u_num_a (
    .clk      (clk),
    .stage_en (stage_en),
    .year     (in_tdata[13:0]),
    .month    (in_tdata[17:14]),
    .day      (in_tdata[22:18]),
    .day_num  (num_a)
  );

  ddd_day_number u_num_b (
    .clk      (clk),
    .stage_en (stage_en),
    .year     (in_tdata[36:23]),
    .month    (in_tdata[40:37]),
    .day      (in_tdata[45:41]),
    .day_num  (num_b)
  );

  // Stage 4: both differences, with the borrow of the first.
  logic [CW:0]   diff_ab_r;
  logic [CW-1:0] diff_ba_r;

  always_ff @(posedge clk) begin
    if (stage_en.s4) begin
      diff_ab_r <= {1'b0, num_a} - {1'b0, num_b};
      diff_ba_r <= num_b - num_a;
    end
  end

  // Stage 5: output register holds the absolute difference.
  logic [CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (stage_en.s5) begin
      count_r <= diff_ab_r[CW] ? diff_ba_r : diff_ab_r[CW-1:0];
    end
  end

  assign out_tdata = {(ddd_pkg::OUT_TDATA_W - CW)'(0), count_r};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned YEAR_W  = ddd_pkg::YEAR_W;
  localparam int unsigned MONTH_W = ddd_pkg::MONTH_W;
  localparam int unsigned DAY_W   = ddd_pkg::DAY_W;
  localparam int unsigned COUNT_W = ddd_pkg::COUNT_W;

  // Calendar rules used by the predictor.
  localparam int unsigned YEAR_CLAMP = 9999;
  localparam int unsigned MARCH      = 3;
  localparam int unsigned COUNT_MAX  = (1 << COUNT_W) - 1;
  localparam int unsigned LAST_MONTH = 12;
  localparam int unsigned MONTH_OFFSET [16] = '{
    0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
  };

  // One calendar date, year in the lowest bits.
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } cal_date_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ddd_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ddd_pkg::OUT_TDATA_W-1:0] out_tdata;

  logic [COUNT_W-1:0] expected_counts [$];
  int unsigned errors = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int unsigned stall_left = 0;

  date_difference_days_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Free-running clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit is_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // Day number counted from year zero, which is taken as a leap year.
  function automatic int unsigned day_index(cal_date_t dt);
    int unsigned y;
    int unsigned n;
    y = 32'(dt.year);
    if (y > YEAR_CLAMP) y = YEAR_CLAMP;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    n = n + MONTH_OFFSET[dt.month] + dt.day;
    if (dt.month >= MARCH && is_leap(y)) n = n + 1;
    return n;
  endfunction

  function automatic logic [COUNT_W-1:0] days_apart(cal_date_t a, cal_date_t b);
    int unsigned na;
    int unsigned nb;
    int unsigned diff;
    na = day_index(a);
    nb = day_index(b);
    diff = (na >= nb) ? na - nb : nb - na;
    if (diff > COUNT_MAX) diff = COUNT_MAX;
    return diff[COUNT_W-1:0];
  endfunction

  function automatic cal_date_t mk_date(int unsigned y, int unsigned m, int unsigned d);
    cal_date_t dt;
    dt.year  = y[YEAR_W-1:0];
    dt.month = m[MONTH_W-1:0];
    dt.day   = d[DAY_W-1:0];
    return dt;
  endfunction

  function automatic cal_date_t random_valid_date();
    return mk_date($urandom_range(1, YEAR_CLAMP), $urandom_range(1, LAST_MONTH),
                   $urandom_range(1, 31));
  endfunction

  function automatic cal_date_t random_raw_date();
    logic [31:0] raw;
    raw = $urandom;
    return raw[$bits(cal_date_t)-1:0];
  endfunction

  // Sends one word and records its expected day count once it is accepted.
  // Valid stays high between words unless a gap is drawn.
  task automatic send_date_pair(cal_date_t a, cal_date_t b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, b, a};
    do @(posedge clk); while (!in_tready);
    expected_counts.push_back(days_apart(a, b));
  endtask

  // Holds the input low until every word in flight has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  // Field extremes, leap rules and out-of-range codes.
  task automatic test_directed();
    send_date_pair(mk_date(2024, 5, 17), mk_date(2024, 5, 17));
    send_date_pair(mk_date(1, 1, 1), mk_date(9999, 12, 31));
    send_date_pair(mk_date(9999, 12, 31), mk_date(1, 1, 1));
    send_date_pair(mk_date(0, 0, 0), mk_date(9999, 15, 31));
    send_date_pair(mk_date(0, 3, 1), mk_date(0, 2, 29));
    send_date_pair(mk_date(16383, 15, 31), mk_date(0, 0, 0));
    send_date_pair(mk_date(10000, 6, 1), mk_date(9999, 6, 1));
    send_date_pair(mk_date(2000, 2, 29), mk_date(2000, 3, 1));
    send_date_pair(mk_date(1900, 2, 28), mk_date(1900, 3, 1));
    send_date_pair(mk_date(2004, 3, 1), mk_date(2004, 1, 1));
    send_date_pair(mk_date(2100, 12, 31), mk_date(2101, 1, 1));
    send_date_pair(mk_date(1999, 0, 5), mk_date(1999, 1, 5));
    send_date_pair(mk_date(1999, 13, 0), mk_date(2000, 0, 0));
    send_date_pair(mk_date(1996, 14, 1), mk_date(1996, 12, 31));
    send_date_pair(mk_date(2023, 2, 31), mk_date(2023, 3, 3));
    send_date_pair(mk_date(2023, 4, 31), mk_date(2023, 5, 1));
    send_date_pair(mk_date(2023, 7, 0), mk_date(2023, 6, 30));
    send_date_pair(mk_date(400, 12, 31), mk_date(401, 1, 1));
    send_date_pair(mk_date(1, 1, 1), mk_date(2, 1, 1));
    send_date_pair(mk_date(5000, 8, 15), mk_date(4999, 8, 15));
    send_date_pair(mk_date(10921, 10, 21), mk_date(5460, 5, 10));
  endtask

  // Months 1 to 12 and days 1 to 31, some pairs in the same year and some in adjacent years.
  task automatic test_random_valid(int unsigned count);
    cal_date_t a;
    cal_date_t b;
    repeat (count) begin
      a = random_valid_date();
      b = random_valid_date();
      case ($urandom_range(0, 3))
        0: b.year = a.year;
        1: b.year = (a.year < YEAR_CLAMP) ? a.year + YEAR_W'(1) : a.year - YEAR_W'(1);
        default: ;
      endcase
      send_date_pair(a, b);
    end
  endtask

  // Every field at its full width, including codes no calendar uses.
  task automatic test_random_raw(int unsigned count);
    repeat (count) send_date_pair(random_raw_date(), random_raw_date());
  endtask

  // Back-to-back words with neither side idling.
  task automatic test_full_rate(int unsigned count);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (count) send_date_pair(random_valid_date(), random_raw_date());
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // The sender stops until the pipeline is empty, then resumes.
  task automatic test_drain_pause(int unsigned count);
    test_random_valid(count);
    wait_drained();
    test_random_valid(count);
  endtask

  // Result side: random stalls on ready and an in-order check of each word.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tvalid && out_tready) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result word, day_count %0d", $time,
                 out_tdata[COUNT_W-1:0]);
        errors++;
      end else begin
        if (out_tdata[COUNT_W-1:0] !== expected_counts[0]) begin
          $display("%0t: day_count mismatch, expected %0d, actual %0d", $time,
                   expected_counts[0], out_tdata[COUNT_W-1:0]);
          errors++;
        end
        void'(expected_counts.pop_front());
      end
      stall_left <= rx_idle ? $urandom_range(0, 3) : 0;
      if (rx_idle && $urandom_range(0, 1)) out_tready <= 1'b0;
    end else if (!out_tready) begin
      if (stall_left == 0) begin
        out_tready <= 1'b1;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // Main sequence.
  initial begin
    int unsigned waited;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_valid(450);
    test_random_raw(200);
    test_full_rate(120);
    test_drain_pause(80);
    in_tvalid <= 1'b0;
    waited = 0;
    while (expected_counts.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (expected_counts.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_counts.size());
      errors++;
    end
    if (errors == 0) begin
      $display("date_difference_days_top regression: pass");
    end else begin
      $display("date_difference_days_top regression: fail");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #1000000;
    $display("date_difference_days_top regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ddd_pkg.sv
rtl/core/ddd_pipe_ctl.sv
rtl/core/ddd_day_number.sv
rtl/core/date_difference_days_top.sv
tb/tb.sv
